// File: hw/rtl/vkn_pkg.sv
// Package: types, key grid tables and codes for the virtual keyboard navigator.
`default_nettype none
package vkn_pkg;

	localparam int STICKY_SLOTS_DEF = 8;
	localparam int RES_DEPTH = 7;
	localparam logic [15:0] INIT_DELAY_RST = 16'd220;
	localparam logic [15:0] REPEAT_PER_RST = 16'd70;

	localparam logic [7:0] SP_RESET  = 8'h80;
	localparam logic [7:0] SP_VOID   = 8'h81;
	localparam logic [7:0] SP_NUMPAD = 8'h82;
	localparam logic [7:0] SP_QWERTY = 8'h83;
	localparam logic [6:0] MOD_SHIFT   = 7'h38;
	localparam logic [6:0] MOD_CTRL    = 7'h36;
	localparam logic [6:0] MOD_CAPS    = 7'h39;
	localparam logic [6:0] MOD_OPTION  = 7'h3a;
	localparam logic [6:0] MOD_COMMAND = 7'h37;

	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_MOD    = 2'd1;
	localparam logic [1:0] KIND_RESET  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic CFG_INIT_DELAY = 1'b0;
	localparam logic CFG_REPEAT_PER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HIDE, ST_TOG, ST_REL, ST_DIR, ST_WALK,
		ST_PRESS, ST_KEYUP, ST_STAT, ST_OUT
	} state_t;

	localparam logic [7:0] QWERTY_ROM [84] = '{
		8'h80, 8'h7f, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81,
		8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81,
		8'h35, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17, 8'h16,
		8'h1a, 8'h1c, 8'h19, 8'h1d, 8'h1b, 8'h18, 8'h33,
		8'h30, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h11, 8'h10,
		8'h20, 8'h22, 8'h1f, 8'h23, 8'h21, 8'h1e, 8'h82,
		8'h36, 8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h04,
		8'h26, 8'h28, 8'h25, 8'h29, 8'h27, 8'h24, 8'h24,
		8'h38, 8'h38, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0b,
		8'h2d, 8'h2e, 8'h2b, 8'h2f, 8'h2c, 8'h38, 8'h38,
		8'h39, 8'h3a, 8'h37, 8'h37, 8'h32, 8'h31, 8'h31,
		8'h31, 8'h31, 8'h2a, 8'h3b, 8'h3c, 8'h3d, 8'h3e
	};

	localparam logic [7:0] KEYPAD_ROM [24] = '{
		8'h83, 8'h83, 8'h83, 8'h83,
		8'h47, 8'h51, 8'h4b, 8'h43,
		8'h59, 8'h5b, 8'h5c, 8'h45,
		8'h56, 8'h57, 8'h58, 8'h4e,
		8'h53, 8'h54, 8'h55, 8'h4c,
		8'h52, 8'h52, 8'h41, 8'h4c
	};

	function automatic logic [3:0] grid_cols(input logic pg);
		return pg ? 4'd4 : 4'd14;
	endfunction

	// Key under a grid position; outside the grid reads as void.
	function automatic logic [7:0] grid_cell(input logic pg, input logic [3:0] x,
			input logic [2:0] y);
		logic [6:0] idx;
		idx = {4'd0, y} * {3'd0, grid_cols(pg)} + {3'd0, x};
		if (x >= grid_cols(pg) || y >= 3'd6)
			return SP_VOID;
		else if (pg)
			return KEYPAD_ROM[idx[4:0]];
		else
			return QWERTY_ROM[idx];
	endfunction

	function automatic logic is_mod(input logic [7:0] c);
		return c == {1'b0, MOD_SHIFT} || c == {1'b0, MOD_CTRL} || c == {1'b0, MOD_CAPS}
			|| c == {1'b0, MOD_OPTION} || c == {1'b0, MOD_COMMAND};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/virtual_keyboard_navigator.sv
// Top level: virtual keyboard cursor, key press and sticky modifier sequencer.
// Sequence: a visible poll runs ST_REL to release held non-Caps latches if a release is pending,
// ST_DIR, ST_WALK steps on a move until a key is reached, ST_PRESS, ST_KEYUP for a key release
// and ST_STAT; a show runs ST_TOG, ST_STAT; a hide ST_HIDE, ST_TOG, ST_STAT; a hidden poll ST_STAT.
// Throughput: one item at a time; results leave one per cycle while m_tready is high, and the input
// is ready again the cycle after the last result transfers. Reset: arst_n resets all control state.
`default_nettype none
module virtual_keyboard_navigator
	import vkn_pkg::*;
#(
	parameter int STICKY_SLOTS = STICKY_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // pad_left, pad_right, pad_up, pad_down, pad_press, now_ms[31:0], 0
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // key_code[6:0], key_down, cursor_col[3:0], cursor_row[2:0], page, visible, 0
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data
);

	localparam int CW = $clog2(STICKY_SLOTS + 1);
	localparam int IW = $clog2(STICKY_SLOTS);

	state_t state_q, state_nx;

	logic [15:0] init_dly_q, rep_per_q;
	logic [3:0]  cur_x_q;
	logic [2:0]  cur_y_q;
	logic        page_q, shown_q, press_prev_q, dir_held_q, dir_rep_q, rel_pend_q;
	logic [31:0] last_ms_q;
	logic [6:0]  held_q [STICKY_SLOTS];
	logic [CW-1:0] held_cnt_q, idx_q;
	logic [4:0]  pads_q;     // left, right, up, down, press
	logic [31:0] now_q;
	logic [6:0]  guard_q;
	logic [1:0]  res_kind_q [RES_DEPTH];
	logic [6:0]  res_code_q [RES_DEPTH];
	logic        res_down_q [RES_DEPTH];
	logic [2:0]  res_cnt_q, out_idx_q;

	logic in_xfer, out_xfer;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// Direction decode: left beats right, up beats down.
	logic any_dir, dir_due, step_now;
	logic [31:0] elapsed;
	assign any_dir = |pads_q[3:0];
	assign elapsed = now_q - last_ms_q;
	assign dir_due = elapsed >= {16'd0, dir_rep_q ? rep_per_q : init_dly_q};
	assign step_now = any_dir && (!dir_held_q || dir_due);

	// One walk step with wraparound.
	logic [3:0] cols, nx;
	logic [2:0] ny;
	logic       walk_more;
	assign cols = grid_cols(page_q);
	always_comb begin
		nx = cur_x_q;
		if (pads_q[0])
			nx = (cur_x_q == 4'd0) ? cols - 4'd1 : cur_x_q - 4'd1;
		else if (pads_q[1])
			nx = (cur_x_q >= cols - 4'd1) ? 4'd0 : cur_x_q + 4'd1;
		ny = cur_y_q;
		if (pads_q[2])
			ny = (cur_y_q == 3'd0) ? 3'd5 : cur_y_q - 3'd1;
		else if (pads_q[3])
			ny = (cur_y_q >= 3'd5) ? 3'd0 : cur_y_q + 3'd1;
	end
	assign walk_more = grid_cell(page_q, nx, ny) == SP_VOID && guard_q > 7'd1;

	// Key under the cursor and press edge.
	logic [7:0] key;
	logic       press_edge, plain_key;
	assign key = grid_cell(page_q, cur_x_q, cur_y_q);
	assign press_edge = pads_q[4] && !press_prev_q;
	assign plain_key = press_edge && !key[7] && !is_mod(key);

	// Modifier latch lookup: lowest matching slot.
	logic          mod_hit;
	logic [CW-1:0] mod_pos;
	always_comb begin
		mod_hit = 1'b0;
		mod_pos = '0;
		for (int j = STICKY_SLOTS - 1; j >= 0; j--) begin
			if (CW'(j) < held_cnt_q && held_q[j] == key[6:0]) begin
				mod_hit = 1'b1;
				mod_pos = CW'(j);
			end
		end
	end

	logic [CW-1:0] idx_m1;
	logic [6:0]    held_rd;
	assign idx_m1 = idx_q - CW'(1);
	assign held_rd = held_q[idx_m1[IW-1:0]];

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (s_tuser)
						state_nx = shown_q ? ST_HIDE : ST_TOG;
					else if (!shown_q)
						state_nx = ST_STAT;
					else
						state_nx = rel_pend_q ? ST_REL : ST_DIR;
				end
			end
			ST_HIDE:  if (idx_q == '0) state_nx = ST_TOG;
			ST_TOG:   state_nx = ST_STAT;
			ST_REL:   if (idx_q == '0) state_nx = ST_DIR;
			ST_DIR:   state_nx = step_now ? ST_WALK : ST_PRESS;
			ST_WALK:  if (!walk_more) state_nx = ST_PRESS;
			ST_PRESS: state_nx = plain_key ? ST_KEYUP : ST_STAT;
			ST_KEYUP: state_nx = ST_STAT;
			ST_STAT:  state_nx = ST_OUT;
			ST_OUT:   if (out_xfer && out_idx_q == res_cnt_q - 3'd1) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Port outputs.
	always_comb begin
		s_tready = state_q == ST_IDLE;
		m_tvalid = state_q == ST_OUT;
		m_tuser  = res_kind_q[out_idx_q];
		m_tlast  = out_idx_q == res_cnt_q - 3'd1;
		m_tdata  = {7'd0, shown_q, page_q, cur_y_q, cur_x_q,
			res_down_q[out_idx_q], res_code_q[out_idx_q]};
	end

	// Result push requests.
	logic       push;
	logic [1:0] push_kind;
	logic [6:0] push_code;
	logic       push_down;
	// Latch removal requests.
	logic          rm;
	logic [CW-1:0] rm_pos;
	always_comb begin
		push = 1'b0; push_kind = KIND_STATUS; push_code = '0; push_down = 1'b0;
		rm = 1'b0; rm_pos = '0;
		unique case (state_q)
			ST_HIDE: if (idx_q != '0) begin
				push = 1'b1; push_kind = KIND_MOD; push_code = held_rd;
			end
			ST_REL: if (idx_q != '0 && held_rd != MOD_CAPS) begin
				push = 1'b1; push_kind = KIND_MOD; push_code = held_rd;
				rm = 1'b1; rm_pos = idx_m1;
			end
			ST_PRESS: if (press_edge) begin
				if (key == SP_RESET) begin
					push = 1'b1; push_kind = KIND_RESET;
				end else if (is_mod(key)) begin
					push_kind = KIND_MOD; push_code = key[6:0];
					if (mod_hit) begin
						push = 1'b1; rm = 1'b1; rm_pos = mod_pos;
					end else if (held_cnt_q < CW'(STICKY_SLOTS)) begin
						push = 1'b1; push_down = 1'b1;
					end
				end else if (!key[7]) begin
					push = 1'b1; push_kind = KIND_KEY; push_code = key[6:0]; push_down = 1'b1;
				end
			end
			ST_KEYUP: begin
				push = 1'b1; push_kind = KIND_KEY; push_code = key[6:0];
			end
			ST_STAT: push = 1'b1;
			default: ;
		endcase
	end

	// Result buffer and modifier latches (no reset: read only below their counts).
	always_ff @(posedge clk) begin
		if (push && res_cnt_q < 3'(RES_DEPTH)) begin
			res_kind_q[res_cnt_q] <= push_kind;
			res_code_q[res_cnt_q] <= push_code;
			res_down_q[res_cnt_q] <= push_down;
		end
		if (rm) begin
			for (int j = 0; j < STICKY_SLOTS - 1; j++)
				if (CW'(j) >= rm_pos && CW'(j + 1) < held_cnt_q)
					held_q[j] <= held_q[j + 1];
		end else if (state_q == ST_PRESS && push && push_down && push_kind == KIND_MOD) begin
			held_q[held_cnt_q[IW-1:0]] <= key[6:0];
		end
		if (in_xfer) begin
			pads_q <= s_tdata[4:0];
			now_q  <= s_tdata[36:5];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_dly_q <= INIT_DELAY_RST;
			rep_per_q <= REPEAT_PER_RST;
			cur_x_q <= 4'd1;
			cur_y_q <= 3'd1;
			page_q <= 1'b0;
			shown_q <= 1'b0;
			press_prev_q <= 1'b0;
			dir_held_q <= 1'b0;
			dir_rep_q <= 1'b0;
			last_ms_q <= '0;
			rel_pend_q <= 1'b0;
			held_cnt_q <= '0;
			idx_q <= '0;
			guard_q <= '0;
			res_cnt_q <= '0;
			out_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				if (cfg_idx == CFG_INIT_DELAY) init_dly_q <= cfg_data;
				if (cfg_idx == CFG_REPEAT_PER) rep_per_q <= cfg_data;
			end
			if (push && res_cnt_q < 3'(RES_DEPTH))
				res_cnt_q <= res_cnt_q + 3'd1;
			if (rm)
				held_cnt_q <= held_cnt_q - CW'(1);
			else if (state_q == ST_PRESS && push && push_down && push_kind == KIND_MOD)
				held_cnt_q <= held_cnt_q + CW'(1);
			unique case (state_q)
				ST_IDLE: if (in_xfer) begin
					res_cnt_q <= '0;
					out_idx_q <= '0;
					idx_q <= held_cnt_q;
				end
				ST_HIDE: begin
					if (idx_q == '0) begin
						held_cnt_q <= '0;
						rel_pend_q <= 1'b0;
					end else
						idx_q <= idx_m1;
				end
				ST_TOG: begin
					shown_q <= !shown_q;
					press_prev_q <= 1'b0;
					dir_held_q <= 1'b0;
					dir_rep_q <= 1'b0;
				end
				ST_REL: begin
					if (idx_q == '0)
						rel_pend_q <= 1'b0;
					else
						idx_q <= idx_m1;
				end
				ST_DIR: begin
					guard_q <= page_q ? 7'd24 : 7'd84;
					if (!any_dir) begin
						dir_held_q <= 1'b0;
						dir_rep_q <= 1'b0;
					end else if (step_now) begin
						dir_rep_q <= dir_held_q;
						dir_held_q <= 1'b1;
						last_ms_q <= now_q;
					end
				end
				ST_WALK: begin
					cur_x_q <= nx;
					cur_y_q <= ny;
					guard_q <= guard_q - 7'd1;
				end
				ST_PRESS: begin
					press_prev_q <= pads_q[4];
					if (press_edge) begin
						if (key == SP_NUMPAD) begin
							page_q <= 1'b1; cur_x_q <= 4'd1; cur_y_q <= 3'd3;
						end else if (key == SP_QWERTY) begin
							page_q <= 1'b0; cur_x_q <= 4'd1; cur_y_q <= 3'd1;
						end else if (plain_key)
							rel_pend_q <= 1'b1;
					end
				end
				ST_OUT: if (out_xfer) out_idx_q <= out_idx_q + 3'd1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
